/* rtl/sacl_pkg.sv */
`default_nettype none
package sacl_pkg;
   localparam int unsigned ADDR_WIDTH = 64;
   localparam int unsigned SET_BITS_WIDTH = 3;
   localparam int unsigned BLOCK_BITS_WIDTH = 6;
   localparam int unsigned WAYS_WIDTH = 4;
   localparam int unsigned CSR_DATA_WIDTH = 6;
   localparam int unsigned CSR_ADDR_WIDTH = 2;
   localparam int unsigned OUT_COUNT_WIDTH = 32;
   localparam int unsigned RSP_DATA_WIDTH = 104;

   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_SET_BITS = 2'd0;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_BLOCK_BITS = 2'd1;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_WAYS_IN_USE = 2'd2;
endpackage
`default_nettype wire

/* rtl/sacl_front.sv */
`default_nettype none
module sacl_front
   import sacl_pkg::*;
#(
   parameter int unsigned MAX_SET_BITS = 6,
   parameter int unsigned MAX_WAYS = 8,
   parameter int unsigned SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1,
   parameter int unsigned NW_W = $clog2(MAX_WAYS + 1)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   output logic                             in_ready,
   input  wire logic [ADDR_WIDTH-1:0]       in_addr,
   input  wire logic [SET_BITS_WIDTH-1:0]   set_bits,
   input  wire logic [BLOCK_BITS_WIDTH-1:0] block_bits,
   input  wire logic [WAYS_WIDTH-1:0]       ways_in_use,
   output logic                             out_valid,
   input  wire logic                        out_ready,
   output logic [SET_W-1:0]                 out_set,
   output logic [ADDR_WIDTH-1:0]            out_tag,
   output logic [NW_W-1:0]                  out_nw
);
   logic [SET_W-1:0]      set_c;
   logic [ADDR_WIDTH-1:0] tag_c;
   logic [NW_W-1:0]       nw_c;
   logic [3:0]            sb;
   logic [6:0]            shift;
   logic [ADDR_WIDTH-1:0] sh_addr;
   logic [ADDR_WIDTH-1:0] set_mask;
   logic                  valid_ff, valid_in;
   logic [SET_W-1:0]      set_ff;
   logic [ADDR_WIDTH-1:0] tag_ff;
   logic [NW_W-1:0]       nw_ff;

   always_comb begin
      sb = ({1'b0, set_bits} > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : {1'b0, set_bits};
      // block_bits never reaches 64, so the shift always stays in range
      sh_addr = in_addr >> block_bits;
      set_mask = ~({ADDR_WIDTH{1'b1}} << sb);
      set_c = SET_W'(sh_addr & set_mask);
      if (MAX_SET_BITS == 0) set_c = '0;
      shift = 7'(sb) + 7'(block_bits);
      tag_c = (shift < 7'd64) ? (in_addr >> shift) : '0;
      if (ways_in_use == '0) nw_c = NW_W'(1);
      else if ({1'b0, ways_in_use} > 5'(MAX_WAYS)) nw_c = NW_W'(MAX_WAYS);
      else nw_c = NW_W'(ways_in_use);
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      if (in_valid && in_ready) begin
         set_ff <= set_c;
         tag_ff <= tag_c;
         nw_ff <= nw_c;
      end
   end

   assign out_valid = valid_ff;
   assign out_set = set_ff;
   assign out_tag = tag_ff;
   assign out_nw = nw_ff;
endmodule
`default_nettype wire

/* rtl/sacl_back.sv */
`default_nettype none
module sacl_back
   import sacl_pkg::*;
#(
   parameter int unsigned MAX_SET_BITS = 6,
   parameter int unsigned MAX_WAYS = 8,
   parameter int unsigned COUNT_WIDTH = 32,
   parameter int unsigned SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1,
   parameter int unsigned WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
   parameter int unsigned NW_W = $clog2(MAX_WAYS + 1)
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   output logic                           in_ready,
   input  wire logic [SET_W-1:0]          in_set,
   input  wire logic [ADDR_WIDTH-1:0]     in_tag,
   input  wire logic [NW_W-1:0]           in_nw,
   output logic                           out_valid,
   input  wire logic                      out_ready,
   output logic [RSP_DATA_WIDTH-1:0]      out_data
);
   localparam int unsigned NUM_SETS = 1 << MAX_SET_BITS;
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOOK = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;
   localparam logic [1:0] ST_CLEAR = 2'd3;

   // tag, valid and recency memories: one row per set, all ways side by side
   logic [ADDR_WIDTH-1:0] tag_mem [NUM_SETS][MAX_WAYS];
   logic [MAX_WAYS-1:0]   valid_mem [NUM_SETS];
   logic [MAX_WAYS-1:0][WAY_W-1:0] rank_mem [NUM_SETS];
   logic [ADDR_WIDTH-1:0] rd_tag  [MAX_WAYS];

   logic [1:0]              state_ff;
   logic [SET_W-1:0]        clr_ff;
   logic [SET_W-1:0]        set_ff;
   logic [ADDR_WIDTH-1:0]   tag_ff;
   logic [NW_W-1:0]         nw_ff;
   logic [COUNT_WIDTH-1:0]  hits_ff, miss_ff, evic_ff;
   logic                    hit_ff, evict_ff;

   logic                    hit_c, free_c, evict_c;
   logic [WAY_W-1:0]        way_c, hway, fway, lway, best;
   logic [MAX_WAYS-1:0][WAY_W-1:0] row_rank;
   logic [MAX_WAYS-1:0]     row_valid;
   logic [MAX_WAYS-1:0][WAY_W-1:0] rank_next, rank_init;
   logic [MAX_WAYS-1:0]     valid_next;
   localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

   assign in_ready = (state_ff == ST_IDLE);
   assign out_valid = (state_ff == ST_DONE);

   always_comb begin
      hit_c = 1'b0; free_c = 1'b0;
      hway = '0; fway = '0; lway = '0; best = '1;
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if (NW_W'(w) < nw_ff) begin
            if (row_valid[w] && rd_tag[w] == tag_ff) begin
               hit_c = 1'b1; hway = WAY_W'(w);
            end
            if (!row_valid[w]) begin
               free_c = 1'b1; fway = WAY_W'(w);
            end
         end
      end
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (NW_W'(w) < nw_ff && (w == 0 || row_rank[w] < best)) begin
            best = row_rank[w]; lway = WAY_W'(w);
         end
      end
      way_c = hit_c ? hway : (free_c ? fway : lway);
      evict_c = !hit_c && !free_c;
      valid_next = row_valid;
      if (!hit_c) valid_next[way_c] = 1'b1;
      for (int w = 0; w < MAX_WAYS; w++) begin
         rank_init[w] = WAY_W'(w);
         if (WAY_W'(w) == way_c) rank_next[w] = WAY_W'(MAX_WAYS - 1);
         else if (row_rank[w] > row_rank[way_c]) rank_next[w] = row_rank[w] - 1'b1;
         else rank_next[w] = row_rank[w];
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         for (int w = 0; w < MAX_WAYS; w++) rd_tag[w] <= tag_mem[in_set][w];
         row_valid <= valid_mem[in_set];
         row_rank <= rank_mem[in_set];
      end
      if (state_ff == ST_LOOK && !hit_c) tag_mem[set_ff][way_c] <= tag_ff;
      // walk every set once after reset to clear valid bits and ranks
      if (state_ff == ST_CLEAR) begin
         valid_mem[clr_ff] <= '0;
         rank_mem[clr_ff] <= rank_init;
      end else if (state_ff == ST_LOOK) begin
         valid_mem[set_ff] <= valid_next;
         rank_mem[set_ff] <= rank_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         hits_ff <= '0; miss_ff <= '0; evic_ff <= '0;
      end else begin
         case (state_ff)
            ST_CLEAR: begin
               if (clr_ff == SET_W'(NUM_SETS - 1)) state_ff <= ST_IDLE;
               else clr_ff <= clr_ff + 1'b1;
            end
            ST_IDLE: begin
               if (in_valid) begin
                  set_ff <= in_set; tag_ff <= in_tag; nw_ff <= in_nw;
                  state_ff <= ST_LOOK;
               end
            end
            ST_LOOK: begin
               hit_ff <= hit_c;
               evict_ff <= evict_c;
               if (hit_c) begin
                  if (hits_ff != CMAX) hits_ff <= hits_ff + 1'b1;
               end else begin
                  if (miss_ff != CMAX) miss_ff <= miss_ff + 1'b1;
               end
               if (evict_c && evic_ff != CMAX) evic_ff <= evic_ff + 1'b1;
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (out_ready) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign out_data = {6'd0, OUT_COUNT_WIDTH'(evic_ff), OUT_COUNT_WIDTH'(miss_ff),
                      OUT_COUNT_WIDTH'(hits_ff), evict_ff, hit_ff};

   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOOK |=> state_ff == ST_DONE)
      else $error("lookup did not finish");
   assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid && $stable(out_data))
      else $error("result changed while stalled");
   assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> state_ff == ST_LOOK)
      else $error("accepted request did not start a lookup");
   assert property (@(posedge clock) disable iff (reset)
      out_valid |-> !(out_data[0] && out_data[1]))
      else $error("hit and eviction together");
endmodule
`default_nettype wire

/* rtl/set_assoc_cache_lru_tags.sv */
`default_nettype none
// Set-associative tag store with LRU replacement. Each request carries a
// byte address; one response per request gives hit and eviction flags and
// saturating hit, miss and eviction totals. A front stage splits the address
// into set and tag and holds it in a one-entry queue; the back stage reads
// the whole set row from the tag, valid and recency memories, then compares
// and writes back tag, valid and recency. An access passes through the back
// stage as read, update and present; the back stage takes a new request only
// once the previous response has left, so a response that waits holds up the
// next request. After reset the back stage walks every set (64 at the
// default size), clearing valid bits and recency ranks before it takes the
// first request.
module set_assoc_cache_lru_tags
   import sacl_pkg::*;
#(
   parameter int unsigned MAX_SET_BITS = 6,
   parameter int unsigned MAX_WAYS = 8,
   parameter int unsigned COUNT_WIDTH = 32
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [ADDR_WIDTH-1:0]     req_tdata,  // access_address
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   // was_hit, was_eviction, hit_total, miss_total, eviction_total
   output logic [RSP_DATA_WIDTH-1:0]      rsp_tdata,
   input  wire logic                      csr_we,
   input  wire logic [CSR_ADDR_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0] csr_wdata
);
   localparam int unsigned SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int unsigned NW_W = $clog2(MAX_WAYS + 1);

   logic [SET_BITS_WIDTH-1:0]   set_bits_ff;
   logic [BLOCK_BITS_WIDTH-1:0] block_bits_ff;
   logic [WAYS_WIDTH-1:0]       ways_ff;
   logic                        q_valid, q_ready;
   logic [SET_W-1:0]            q_set;
   logic [ADDR_WIDTH-1:0]       q_tag;
   logic [NW_W-1:0]             q_nw;

   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff <= 3'd4;
         block_bits_ff <= 6'd4;
         ways_ff <= 4'd8;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SET_BITS: set_bits_ff <= csr_wdata[SET_BITS_WIDTH-1:0];
            CSR_BLOCK_BITS: block_bits_ff <= csr_wdata;
            CSR_WAYS_IN_USE: ways_ff <= csr_wdata[WAYS_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   sacl_front #(.MAX_SET_BITS(MAX_SET_BITS), .MAX_WAYS(MAX_WAYS)) u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready), .in_addr(req_tdata),
      .set_bits(set_bits_ff), .block_bits(block_bits_ff), .ways_in_use(ways_ff),
      .out_valid(q_valid), .out_ready(q_ready),
      .out_set(q_set), .out_tag(q_tag), .out_nw(q_nw)
   );

   sacl_back #(.MAX_SET_BITS(MAX_SET_BITS), .MAX_WAYS(MAX_WAYS),
               .COUNT_WIDTH(COUNT_WIDTH)) u_back (
      .clock, .reset,
      .in_valid(q_valid), .in_ready(q_ready),
      .in_set(q_set), .in_tag(q_tag), .in_nw(q_nw),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_data(rsp_tdata)
   );
endmodule
`default_nettype wire
